/* hw/rtl/apf_pkg.sv */
// Package for the articulation point finder: payload structs, walk stack
// entry, sequencer states and fixed field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package apf_pkg;

  localparam int IDX_W = 6;
  localparam int DEP_W = 7;

  localparam logic KIND_EDGE    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] end_a;
    logic [IDX_W-1:0] end_b;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex;
    logic             found;
    logic [IDX_W-1:0] point_count;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] vertex;
    logic [IDX_W-1:0] parent;
    logic [DEP_W-1:0] cursor;
    logic [DEP_W-1:0] depth;
    logic [DEP_W-1:0] low;
  } stk_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_B,
    S_ROOT,
    S_SCAN,
    S_BACK,
    S_POP,
    S_EMIT
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/articulation_point_finder_unit.sv */
// Articulation point finder top level: adjacency, depth and walk stack memories
// with the depth-first walk sequencer. Depends on apf_pkg.
`timescale 1ns / 1ps
`default_nettype none
// An edge transfer makes one write per adjacency row (bit-masked, but a row's
// first write since clearing replaces it). A compute transfer walks the graph:
// S_ROOT scans the vertices and starts a component root at each unvisited one;
// per adjacency hit S_SCAN takes a tree edge or sends a back edge to S_BACK
// via the depth memory read; a retreat reads the stack memory, pops in S_POP.
// Results leave one per cycle from the output register while out_stall is low;
// the graph is cleared on the last one through per-row valid and visited flags,
// so no clearing pass is needed. Input stalls in S_EDGE_B and from a compute
// transfer until its last result is loaded; node_count is capped at MAX_VERTICES.
module articulation_point_finder_unit #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire apf_pkg::in_item_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output apf_pkg::out_item_t      out_item,
  input  wire logic               cfg_we,
  input  wire logic [6:0]         cfg_data
);
  import apf_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam logic [DEP_W-1:0] NMAX = DEP_W'(MAX_VERTICES);

  state_t st_r, st_nxt;

  logic [6:0]              node_count_r;
  logic [DEP_W-1:0]        n_r, n_nxt;
  logic [DEP_W-1:0]        root_r, root_nxt;
  logic [DEP_W-1:0]        sp_r, sp_nxt;
  logic [DEP_W-1:0]        rcc_r, rcc_nxt;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic [IDX_W-1:0]        ea_r, ea_nxt, eb_r, eb_nxt;
  stk_entry_t              top_r, top_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt, rv_r, rv_nxt, cut_r, cut_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_item_r, out_item_nxt;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_q;
  logic                    adj_ok_r;
  logic [DEP_W-1:0]        dep_mem [MAX_VERTICES];
  logic [DEP_W-1:0]        dep_q;
  stk_entry_t              stk_mem [MAX_VERTICES];
  stk_entry_t              stk_q;

  logic                    adj_we, adj_wfull, adj_re;
  logic [IDX_W-1:0]        adj_wa, adj_wb, adj_ra;
  logic                    dep_we, dep_re;
  logic [IDX_W-1:0]        dep_wa, dep_ra;
  logic [DEP_W-1:0]        dep_wd;
  logic                    stk_we, stk_re;
  logic [IDX_W-1:0]        stk_wa, stk_ra;
  stk_entry_t              stk_wd;

  logic                    in_acc, edge_ok, load;
  logic [MAX_VERTICES-1:0] row, hits, rest;
  logic                    got;
  logic [IDX_W-1:0]        u, first;

  assign in_acc  = in_valid && (st_r == S_IDLE);
  assign edge_ok = ({1'b0, in_item.end_a} < NMAX) && ({1'b0, in_item.end_b} < NMAX);
  assign load    = !out_valid_r || !out_stall;

  always_comb begin
    row = adj_ok_r ? adj_q : '0;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      hits[i] = row[i] && (DEP_W'(i) >= top_r.cursor) && (DEP_W'(i) < n_r) &&
                (IDX_W'(i) != top_r.vertex) && (IDX_W'(i) != top_r.parent);
    end
    got = |hits;
    u = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (hits[i]) u = IDX_W'(i);
    end
    first = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cut_r[i]) first = IDX_W'(i);
    end
    rest = cut_r & ~({{(MAX_VERTICES-1){1'b0}}, 1'b1} << first[AW-1:0]);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.kind == KIND_COMPUTE) st_nxt = S_ROOT;
          else if (edge_ok) st_nxt = S_EDGE_B;
        end
      end
      S_EDGE_B: st_nxt = S_IDLE;
      S_ROOT: begin
        if (root_r >= n_r) st_nxt = S_EMIT;
        else if (!vis_r[root_r[AW-1:0]]) st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (got) st_nxt = vis_r[u[AW-1:0]] ? S_BACK : S_SCAN;
        else st_nxt = (sp_r > DEP_W'(1)) ? S_POP : S_ROOT;
      end
      S_BACK: st_nxt = S_SCAN;
      S_POP:  st_nxt = S_SCAN;
      S_EMIT: begin
        if (load && ((cnt_r == '0) || (rest == '0))) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    n_nxt = n_r; root_nxt = root_r; sp_nxt = sp_r; rcc_nxt = rcc_r; cnt_nxt = cnt_r;
    ea_nxt = ea_r; eb_nxt = eb_r; top_nxt = top_r;
    vis_nxt = vis_r; rv_nxt = rv_r; cut_nxt = cut_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt = out_item_r;
    adj_we = 1'b0; adj_wfull = 1'b0; adj_wa = '0; adj_wb = '0;
    adj_re = 1'b0; adj_ra = '0;
    dep_we = 1'b0; dep_wa = '0; dep_wd = '0; dep_re = 1'b0; dep_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = top_r; stk_re = 1'b0; stk_ra = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item.kind == KIND_COMPUTE) begin
            n_nxt = ({1'b0, node_count_r} > {1'b0, NMAX}) ? NMAX : node_count_r;
            root_nxt = '0;
          end else if (edge_ok) begin
            adj_we = 1'b1; adj_wa = in_item.end_a; adj_wb = in_item.end_b;
            adj_wfull = !rv_r[in_item.end_a[AW-1:0]];
            rv_nxt[in_item.end_a[AW-1:0]] = 1'b1;
            ea_nxt = in_item.end_a; eb_nxt = in_item.end_b;
          end
        end
      end
      S_EDGE_B: begin
        adj_we = 1'b1; adj_wa = eb_r; adj_wb = ea_r;
        adj_wfull = !rv_r[eb_r[AW-1:0]];
        rv_nxt[eb_r[AW-1:0]] = 1'b1;
      end
      S_ROOT: begin
        if (root_r < n_r) begin
          if (vis_r[root_r[AW-1:0]]) begin
            root_nxt = root_r + DEP_W'(1);
          end else begin
            vis_nxt[root_r[AW-1:0]] = 1'b1;
            dep_we = 1'b1; dep_wa = root_r[IDX_W-1:0]; dep_wd = DEP_W'(1);
            top_nxt = '{vertex: root_r[IDX_W-1:0], parent: root_r[IDX_W-1:0],
                        cursor: '0, depth: DEP_W'(1), low: DEP_W'(1)};
            sp_nxt = DEP_W'(1); rcc_nxt = '0;
            adj_re = 1'b1; adj_ra = root_r[IDX_W-1:0];
          end
        end
      end
      S_SCAN: begin
        if (got) begin
          top_nxt.cursor = {1'b0, u} + DEP_W'(1);
          if (vis_r[u[AW-1:0]]) begin
            dep_re = 1'b1; dep_ra = u;
          end else begin
            if ({1'b0, top_r.vertex} == root_r) rcc_nxt = rcc_r + DEP_W'(1);
            stk_we = 1'b1; stk_wa = IDX_W'(sp_r - DEP_W'(1));
            stk_wd = top_r; stk_wd.cursor = {1'b0, u} + DEP_W'(1);
            dep_we = 1'b1; dep_wa = u; dep_wd = top_r.depth + DEP_W'(1);
            vis_nxt[u[AW-1:0]] = 1'b1;
            top_nxt = '{vertex: u, parent: top_r.vertex, cursor: '0,
                        depth: top_r.depth + DEP_W'(1), low: top_r.depth + DEP_W'(1)};
            sp_nxt = sp_r + DEP_W'(1);
            adj_re = 1'b1; adj_ra = u;
          end
        end else if (sp_r > DEP_W'(1)) begin
          sp_nxt = sp_r - DEP_W'(1);
          stk_re = 1'b1; stk_ra = IDX_W'(sp_r - DEP_W'(2));
        end else begin
          sp_nxt = '0;
          if (rcc_r > DEP_W'(1)) begin
            cut_nxt[root_r[AW-1:0]] = 1'b1;
            cnt_nxt = cnt_r + IDX_W'(1);
          end
          root_nxt = root_r + DEP_W'(1);
        end
      end
      S_BACK: begin
        if (dep_q < top_r.low) top_nxt.low = dep_q;
      end
      S_POP: begin
        top_nxt = stk_q;
        if (top_r.low < stk_q.low) top_nxt.low = top_r.low;
        if (({1'b0, stk_q.vertex} != root_r) && (top_r.low >= stk_q.depth) &&
            !cut_r[stk_q.vertex[AW-1:0]]) begin
          cut_nxt[stk_q.vertex[AW-1:0]] = 1'b1;
          cnt_nxt = cnt_r + IDX_W'(1);
        end
        adj_re = 1'b1; adj_ra = stk_q.vertex;
      end
      S_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          if (cnt_r == '0) begin
            out_item_nxt = '{vertex: '0, found: 1'b0, point_count: '0, last: 1'b1};
          end else begin
            out_item_nxt = '{vertex: first, found: 1'b1, point_count: cnt_r,
                             last: (rest == '0)};
            cut_nxt = rest;
          end
          if ((cnt_r == '0) || (rest == '0)) begin
            vis_nxt = '0; rv_nxt = '0; cut_nxt = '0; cnt_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      node_count_r <= 7'd64;
      n_r <= '0; root_r <= '0; sp_r <= '0; rcc_r <= '0; cnt_r <= '0;
      vis_r <= '0; rv_r <= '0; cut_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) node_count_r <= cfg_data;
      n_r <= n_nxt; root_r <= root_nxt; sp_r <= sp_nxt; rcc_r <= rcc_nxt;
      cnt_r <= cnt_nxt;
      vis_r <= vis_nxt; rv_r <= rv_nxt; cut_r <= cut_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ea_r <= ea_nxt; eb_r <= eb_nxt; top_r <= top_nxt; out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      if (adj_wfull)
        adj_mem[adj_wa[AW-1:0]] <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << adj_wb[AW-1:0];
      else
        adj_mem[adj_wa[AW-1:0]][adj_wb[AW-1:0]] <= 1'b1;
    end
    if (adj_re) begin
      adj_q    <= adj_mem[adj_ra[AW-1:0]];
      adj_ok_r <= rv_r[adj_ra[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (dep_we) dep_mem[dep_wa[AW-1:0]] <= dep_wd;
    if (dep_re) dep_q <= dep_mem[dep_ra[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa[AW-1:0]] <= stk_wd;
    if (stk_re) stk_q <= stk_mem[stk_ra[AW-1:0]];
  end

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_EMIT))
    else $error("result loaded outside emit");

  a_count_tracks_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_EMIT) |-> (int'(cnt_r) == $countones(cut_r)))
    else $error("point count out of step with cut flags");

  a_walk_has_top: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN || st_r == S_BACK || st_r == S_POP) |-> (sp_r != '0))
    else $error("walk step with empty stack");

endmodule
`default_nettype wire
